[rtl/qft_pkg.sv]
`default_nettype none

package qft_pkg;

  // Delimiter lanes: the packed register holds four bytes, the design limit may be lower.
  localparam int unsigned MaxDelims = 4;
  localparam int unsigned NumLanes  = (MaxDelims < 4) ? MaxDelims : 4;

  // APB register map, word index at paddr[3:2]
  localparam int unsigned AddrW = 4;
  localparam logic [1:0] RegDelimBytes = 2'd0;
  localparam logic [1:0] RegDelimUsed  = 2'd1;
  localparam logic [1:0] RegQuoteByte  = 2'd2;

  localparam logic [7:0] QuoteReset = 8'd34;

  typedef enum logic [1:0] {
    PhStart = 2'd0,
    PhSkip  = 2'd1,
    PhPlain = 2'd2,
    PhQuote = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_mark;
  } in_req_t;

  typedef struct packed {
    logic [7:0] tok_byte;
    logic       tok_end;
  } out_rsp_t;

  typedef struct packed {
    logic [31:0] delim_bytes;
    logic [2:0]  delim_used;
    logic [7:0]  quote_byte;
  } cfg_t;

  typedef struct packed {
    logic     emit;
    out_rsp_t rsp;
  } step_t;

endpackage

`default_nettype wire

[rtl/quoted_field_tokenizer.sv]
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+--------------------------------
// in        | input     | in_valid_i / in_ready_o   | in_req_i  (in_byte, end_mark)
// out       | output    | out_valid_o / out_ready_i | out_rsp_o (tok_byte, tok_end)
// apb       | input     | psel, penable, pwrite     | paddr, pwdata -> prdata
//
// One byte request per cycle, sustained while out is not stalled.
// The request register feeds the phase logic, whose result lands in the output register.
// Reset clears both valid flags, returns the phase to token start and loads the
// register reset values (no delimiters, quote byte 34).
// A stall on out holds the output register; the request register still takes a new
// byte whenever its current one can move on, so in_ready_o drops only on a full pipe.
`default_nettype none

module quoted_field_tokenizer (
  input  wire               clk_i,
  input  wire               rst_ni,
  // request channel
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  qft_pkg::in_req_t  in_req_i,
  // result channel
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output qft_pkg::out_rsp_t out_rsp_o,
  // configuration port
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire [3:0]         paddr,
  input  wire [31:0]        pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import qft_pkg::*;

  // Configuration registers
  cfg_t cfg_q;
  logic cfg_wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delim_bytes <= 32'd0;
      cfg_q.delim_used  <= 3'd0;
      cfg_q.quote_byte  <= QuoteReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegDelimBytes: cfg_q.delim_bytes <= pwdata;
        RegDelimUsed:  cfg_q.delim_used  <= pwdata[2:0];
        RegQuoteByte:  cfg_q.quote_byte  <= pwdata[7:0];
        default: ;  // unmapped word, drop the write
      endcase
    end
  end

  // Read back; unmapped word reads as zero
  always_comb begin
    unique case (reg_idx)
      RegDelimBytes: prdata = cfg_q.delim_bytes;
      RegDelimUsed:  prdata = {29'd0, cfg_q.delim_used};
      RegQuoteByte:  prdata = {24'd0, cfg_q.quote_byte};
      default:       prdata = 32'd0;
    endcase
  end

  // Request register stage
  logic    req_valid_q;
  in_req_t req_q;
  logic    req_adv;   // held request is classified and leaves this cycle

  // Result register stage
  logic     out_valid_q;
  out_rsp_t out_rsp_q;

  phase_e phase_q, phase_d;
  step_t  step;

  // The held request may move on when the output register is free or being drained.
  assign req_adv    = req_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || req_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  qft_classify u_classify (
    .phase_i (phase_q),
    .req_i   (req_q),
    .cfg_i   (cfg_q),
    .phase_o (phase_d),
    .step_o  (step)
  );

  // Advance the phase only when the held byte is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
    end else if (req_adv) begin
      phase_q <= phase_d;
    end
  end

  // Output register: load a new result, else clear once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_adv && step.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_adv && step.emit) begin
      out_rsp_q <= step.rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTHESIS
  // A token end never carries a character
  a_end_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.tok_end |-> out_rsp_o.tok_byte == 8'd0)
    else $error("token end with nonzero byte");

  // An end marker always yields a token end and resets the phase
  a_end_mark_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_adv && req_q.end_mark |=> out_valid_q && out_rsp_q.tok_end && phase_q == PhStart)
    else $error("end marker did not close the token");

  // Backpressure on in only when both stages are full and out is stalled
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> req_valid_q && out_valid_q && !out_ready_i)
    else $error("in_ready_o low without a full pipe");

  // Phase holds while the request stage is stalled
  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && !req_adv |=> $stable(phase_q))
    else $error("phase moved without a consumed byte");
`endif

endmodule

`default_nettype wire

[rtl/qft_classify.sv]
`default_nettype none

module qft_classify (
  input  qft_pkg::phase_e  phase_i,
  input  qft_pkg::in_req_t req_i,
  input  qft_pkg::cfg_t    cfg_i,
  output qft_pkg::phase_e  phase_o,
  output qft_pkg::step_t   step_o
);
  import qft_pkg::*;

  logic [NumLanes-1:0] lane_hit;
  logic                is_delim;
  logic                is_quote;

  // Lane i is active while delim_used exceeds i; lanes past NumLanes never exist.
  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      lane_hit[i] = (cfg_i.delim_used > 3'(i)) &&
                    (cfg_i.delim_bytes[8*i +: 8] == req_i.in_byte);
    end
  end

  assign is_delim = |lane_hit;
  assign is_quote = (req_i.in_byte == cfg_i.quote_byte);

  // Next phase
  always_comb begin
    phase_o = phase_i;
    if (req_i.end_mark) begin
      phase_o = PhStart;
    end else begin
      unique case (phase_i)
        PhStart: begin
          if (is_quote)      phase_o = PhQuote;
          else if (is_delim) phase_o = PhSkip;
          else               phase_o = PhPlain;
        end
        PhSkip: begin
          if (!is_delim) phase_o = PhPlain;
        end
        PhPlain: begin
          if (is_delim) phase_o = PhStart;
        end
        PhQuote: begin
          if (is_quote) phase_o = PhStart;
        end
        default: phase_o = PhStart;
      endcase
    end
  end

  // Result
  always_comb begin
    step_o.emit         = 1'b1;
    step_o.rsp.tok_byte = req_i.in_byte;
    step_o.rsp.tok_end  = 1'b0;
    if (req_i.end_mark) begin
      step_o.rsp.tok_byte = 8'd0;
      step_o.rsp.tok_end  = 1'b1;
    end else begin
      unique case (phase_i)
        PhStart: begin
          if (is_quote || is_delim) step_o.emit = 1'b0;
        end
        PhSkip: begin
          if (is_delim) step_o.emit = 1'b0;
        end
        PhPlain: begin
          if (is_delim) begin
            step_o.rsp.tok_byte = 8'd0;
            step_o.rsp.tok_end  = 1'b1;
          end
        end
        PhQuote: begin
          if (is_quote) begin
            step_o.rsp.tok_byte = 8'd0;
            step_o.rsp.tok_end  = 1'b1;
          end
        end
        default: step_o.emit = 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
module tb;
  import qft_pkg::*;

  // Keep clocking after the last expected token so that a request with no result
  // (a dropped delimiter, an opening quote) has left the two-stage pipe.
  localparam int unsigned SettleCycles = 8;
  // Slowest correct run is roughly 2000 requests plus one long stall.
  localparam int unsigned CycleLimit   = 200000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_req_t           in_req_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_rsp_t          out_rsp_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [AddrW-1:0]  paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Mirror of the tokenizer: its registers, its phase and the tokens still owed.
  cfg_t              tok_cfg;
  phase_e            tok_phase;
  out_rsp_t          token_q[$];

  int unsigned       err_cnt       = 0;
  int unsigned       req_sent      = 0;
  int unsigned       cycle_cnt     = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  // A long hold-off on the result side is requested by bumping stall_req.
  int unsigned       stall_len     = 0;
  int unsigned       stall_req     = 0;
  int unsigned       stall_seen    = 0;
  int unsigned       stall_left    = 0;

  quoted_field_tokenizer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  // Active delimiter lanes: delim_used saturates at the number of lanes the block has.
  function automatic int unsigned active_lanes();
    return (tok_cfg.delim_used > NumLanes) ? NumLanes : int'(tok_cfg.delim_used);
  endfunction

  function automatic bit is_delim_byte(input logic [7:0] b);
    int unsigned lanes;
    lanes = active_lanes();
    for (int unsigned i = 0; i < lanes; i++) begin
      if (tok_cfg.delim_bytes[8*i +: 8] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the phase by one request; return 1 when a token byte or token end is due.
  function automatic bit tokenize_byte(input in_req_t req, output out_rsp_t rsp);
    logic [7:0] b;
    b   = req.in_byte;
    rsp = '{tok_byte: b, tok_end: 1'b0};
    // The end marker closes whatever is open, an empty token included.
    if (req.end_mark) begin
      tok_phase = PhStart;
      rsp       = '{tok_byte: 8'h00, tok_end: 1'b1};
      return 1'b1;
    end
    case (tok_phase)
      PhStart: begin
        // Quote wins over the delimiter check, even when it is in the set.
        if (b == tok_cfg.quote_byte) begin
          tok_phase = PhQuote;
          return 1'b0;
        end
        if (is_delim_byte(b)) begin
          tok_phase = PhSkip;
          return 1'b0;
        end
        tok_phase = PhPlain;
      end
      PhSkip: begin
        // A quote outside the delimiter set is an ordinary first character here.
        if (is_delim_byte(b)) return 1'b0;
        tok_phase = PhPlain;
      end
      PhPlain: begin
        if (is_delim_byte(b)) begin
          tok_phase = PhStart;
          rsp       = '{tok_byte: 8'h00, tok_end: 1'b1};
        end
      end
      default: begin
        if (b == tok_cfg.quote_byte) begin
          tok_phase = PhStart;
          rsp       = '{tok_byte: 8'h00, tok_end: 1'b1};
        end
      end
    endcase
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request, idling first at random; valid stays high on return so that
  // back-to-back requests never drop it. Predict at the accepting edge.
  task automatic send_req(input in_req_t req);
    out_rsp_t rsp;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    req_sent++;
    if (tokenize_byte(req, rsp)) token_q.push_back(rsp);
  endtask

  task automatic send_char(input logic [7:0] b);
    send_req('{in_byte: b, end_mark: 1'b0});
  endtask

  // The byte under an end marker is ignored, so give it random content.
  task automatic send_end();
    send_req('{in_byte: 8'($urandom_range(0, 255)), end_mark: 1'b1});
  endtask

  // Drop valid, wait for every owed token, then let the pipe run dry.
  task automatic drain_tokens();
    in_valid_i <= 1'b0;
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------

  // Write one register, then read it back over the same port.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    case (idx)
      RegDelimBytes: mask = 32'hFFFF_FFFF;
      RegDelimUsed:  mask = 32'h0000_0007;
      default:       mask = 32'h0000_00FF;
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegDelimBytes: tok_cfg.delim_bytes = value;
      RegDelimUsed:  tok_cfg.delim_used  = value[2:0];
      default:       tok_cfg.quote_byte  = value[7:0];
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & mask) !== (value & mask)) begin
      $error("register %0d readback: expected %0h, got %0h", idx, value & mask, prdata & mask);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] delims, input logic [2:0] used,
                            input logic [7:0] quote);
    write_reg(RegDelimBytes, delims);
    write_reg(RegDelimUsed, {29'd0, used});
    write_reg(RegQuoteByte, {24'd0, quote});
  endtask

  // ---------------------------------------------------------------------------
  // Random string content
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick_delim();
    int unsigned lanes;
    lanes = active_lanes();
    if (lanes == 0) return 8'($urandom_range(0, 255));
    return tok_cfg.delim_bytes[8*$urandom_range(0, lanes - 1) +: 8];
  endfunction

  function automatic logic [7:0] pick_byte(input bit no_delim, input bit no_quote);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((no_delim && is_delim_byte(b)) || (no_quote && b == tok_cfg.quote_byte));
    return b;
  endfunction

  // Mostly well-formed strings: delimiter runs, plain and quoted tokens, an end marker.
  // About a fifth is raw noise with the odd stray end marker.
  task automatic run_strings(input int unsigned n_req);
    int unsigned stop;
    int unsigned n_tok;
    bit          unclosed;
    stop = req_sent + n_req;
    while (req_sent < stop) begin
      if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(1, 8)) begin
          send_req('{in_byte: 8'($urandom_range(0, 255)),
                     end_mark: ($urandom_range(9) == 0)});
        end
      end else begin
        n_tok    = $urandom_range(0, 4);
        unclosed = 1'b0;
        if ($urandom_range(1)) repeat ($urandom_range(1, 2)) send_char(pick_delim());
        for (int unsigned t = 0; t < n_tok && !unclosed; t++) begin
          if ($urandom_range(99) < 40) begin
            // Quoted token: delimiters inside are plain characters, lean on them.
            send_char(tok_cfg.quote_byte);
            repeat ($urandom_range(0, 6)) begin
              if ($urandom_range(3) == 0) send_char(pick_delim());
              else send_char(pick_byte(1'b0, 1'b1));
            end
            if ($urandom_range(9) != 0) send_char(tok_cfg.quote_byte);
            else unclosed = 1'b1;
          end else begin
            // Plain token; a leading quote is allowed once skipping is under way.
            repeat ($urandom_range(1, 6)) send_char(pick_byte(1'b1, tok_phase == PhStart));
          end
          if (!unclosed && (t + 1 < n_tok || $urandom_range(1))) begin
            repeat ($urandom_range(1, 3)) send_char(pick_delim());
          end
        end
        send_end();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_cases();
    // Reset settings: no delimiters, so a space is text; quote is the double quote.
    send_char("a");
    send_char(8'h22);
    send_char(" ");
    send_char(8'hFF);
    send_char(8'h22);
    send_end();
    send_end();                       // empty token
    drain_tokens();

    // Quote inside the delimiter set, zero byte as a delimiter, delim_used saturated.
    set_config(32'hFF22_002C, 3'd7, 8'h22);
    send_char(",");
    send_char(",");
    send_char(8'h22);                 // dropped while skipping
    send_char("x");
    send_char(8'h00);                 // closes the plain token
    send_char(8'h22);                 // opens a quote: quote check comes first
    send_char(",");
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h22);
    send_char(8'hFF);
    send_end();
    drain_tokens();

    // Zero byte as the quote; unclosed quote; quote met while skipping.
    set_config(32'h0000_002C, 3'd1, 8'h00);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(",");
    send_end();                       // closes the open quote
    send_char(",");
    send_char(8'h00);                 // not a delimiter, so it starts a plain token
    send_end();
    drain_tokens();
  endtask

  task automatic test_random_profiles();
    for (int unsigned prof = 0; prof < 3; prof++) begin
      case (prof)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int unsigned seg = 0; seg < 3; seg++) begin
        case (3 * prof + seg)
          0: set_config($urandom, 3'd2, 8'h22);
          1: set_config(32'hFFFF_FFFF, 3'd7, 8'h00);
          2: set_config(32'h0000_0000, 3'd4, 8'hFF);
          3: set_config($urandom, 3'd0, 8'($urandom_range(0, 255)));
          default: set_config($urandom, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        endcase
        run_strings(200);
        drain_tokens();
      end
    end
  endtask

  // Hold the result side off for a long stretch while requests keep coming, so the
  // pipe fills and the request side stalls.
  task automatic test_output_stall();
    set_config(32'h3B2C_0920, 3'd4, 8'h27);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_len     = 400;
    stall_req++;
    run_strings(120);
    drain_tokens();
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (stall_req != stall_seen) begin
      stall_seen = stall_req;
      stall_left = stall_len;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted token against the oldest one owed.
  always @(posedge clk_i) begin
    out_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (token_q.size() == 0) begin
        $error("unexpected token result: tok_byte %0h tok_end %0b",
               out_rsp_o.tok_byte, out_rsp_o.tok_end);
        err_cnt++;
      end else begin
        want = token_q.pop_front();
        if (out_rsp_o.tok_end !== want.tok_end) begin
          $error("tok_end: expected %0b, got %0b", want.tok_end, out_rsp_o.tok_end);
          err_cnt++;
        end
        if (out_rsp_o.tok_byte !== want.tok_byte) begin
          $error("tok_byte: expected %0h, got %0h", want.tok_byte, out_rsp_o.tok_byte);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    tok_cfg   = '{delim_bytes: 32'd0, delim_used: 3'd0, quote_byte: QuoteReset};
    tok_phase = PhStart;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_random_profiles();
    test_output_stall();
    drain_tokens();
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
